// ===== sv/fingertip_force_conditioner_defines.svh =====
// Assertion macros shared by the fingertip force conditioner RTL.
`ifndef FINGERTIP_FORCE_CONDITIONER_DEFINES_SVH
`define FINGERTIP_FORCE_CONDITIONER_DEFINES_SVH
`ifndef ASSERT_OFF
`define FFC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("label failed");
`define FFC_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("label failed");
`else
`define FFC_ASSERT(label, clk, rst, prop)
`define FFC_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== sv/ffc_pkg.sv =====
// Package with payload types, state codes and constants of the fingertip force conditioner.
package ffc_pkg;
  localparam int ValueWidth = 24;
  localparam int RateWidth = 40;
  localparam logic [11:0] DefaultTps = 12'd500;
  localparam logic [1:0] RegAlpha = 2'd0;
  localparam logic [1:0] RegTps = 2'd1;
  localparam logic [1:0] RegMinContacts = 2'd2;
  localparam logic [1:0] RegThreshold = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_MUL_TPS, ST_MUL_EMA, ST_DONE
  } ffc_state_t;

  typedef struct packed {
    logic [1:0] finger_index;
    logic inference_valid;
    logic [7:0] contact_level;
    logic signed [ValueWidth-1:0] force_x;
    logic signed [ValueWidth-1:0] force_y;
    logic signed [ValueWidth-1:0] force_z;
    logic signed [ValueWidth-1:0] disp_x;
    logic signed [ValueWidth-1:0] disp_y;
    logic signed [ValueWidth-1:0] disp_z;
    logic last_in_tick;
  } ffc_in_t;

  typedef struct packed {
    logic [1:0] finger_out;
    logic [ValueWidth-1:0] force_norm;
    logic signed [39:0] force_slope;
    logic [ValueWidth-1:0] displacement_magnitude;
    logic contact_active;
    logic [2:0] contact_total;
    logic [ValueWidth-1:0] peak_force;
    logic grasp_found;
    logic tick_done;
  } ffc_out_t;

  // Control from the sequencer to a serial arithmetic unit.
  typedef struct packed {
    logic start;
    logic busy;
  } ffc_unit_ctl_t;
endpackage

// ===== sv/ffc_norm.sv =====
// Serial Euclidean norm: squares accumulated by shift-add, then a bit-pair square root.
module ffc_norm import ffc_pkg::*; #(
  parameter int VW = 24
) (
  input  logic clk,
  input  logic rst,
  input  ffc_unit_ctl_t ctl,
  input  logic signed [VW-1:0] ax,
  input  logic signed [VW-1:0] ay,
  input  logic signed [VW-1:0] az,
  output logic [VW-1:0] mag,
  output logic done
);
  localparam int SW = 2 * VW + 2;
  localparam int RW = VW + 1;
  localparam int CW = $clog2(3 * VW + VW + 2);
  localparam int SqSteps = 3 * VW;
  localparam int RootSteps = SW / 2;

  logic [VW-1:0] ux, uy, uz;
  logic [VW-1:0] mplier;
  logic [SW-1:0] mshift;
  logic [SW-1:0] acc;
  logic [SW-1:0] acc_add;
  logic [SW-1:0] rem_src;
  logic [RW+1:0] rem;
  logic [RW-1:0] root;
  logic [CW-1:0] step;
  logic phase;
  logic [RW+1:0] trial;
  logic [RW+1:0] rem_shift;

  // Absolute values of the three components.
  assign ux = ax[VW-1] ? VW'(-ax) : VW'(ax);
  assign uy = ay[VW-1] ? VW'(-ay) : VW'(ay);
  assign uz = az[VW-1] ? VW'(-az) : VW'(az);

  assign rem_shift = {rem[RW-1:0], rem_src[SW-1 -: 2]};
  assign trial = {root, 2'b01};

  // The multiplicand moves left one place per multiplier bit.
  assign acc_add = mplier[0] ? acc + mshift : acc;

  // While busy, one multiplier bit per cycle, then one root bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      phase <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        step <= '0;
        phase <= 1'b0;
        acc <= '0;
        mshift <= SW'(ux);
        mplier <= ux;
      end else if (ctl.busy && !phase) begin
        acc <= acc_add;
        rem_src <= acc_add;
        if (step == CW'(VW - 1)) begin
          mshift <= SW'(uy);
          mplier <= uy;
        end else if (step == CW'(2 * VW - 1)) begin
          mshift <= SW'(uz);
          mplier <= uz;
        end else begin
          mshift <= mshift << 1;
          mplier <= mplier >> 1;
        end
        if (step == CW'(SqSteps - 1)) begin
          step <= '0;
          phase <= 1'b1;
          rem <= '0;
          root <= '0;
        end else begin
          step <= step + 1'b1;
        end
      end else if (ctl.busy && phase && step < CW'(RootSteps)) begin
        if (rem_shift >= trial) begin
          rem <= rem_shift - trial;
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          root <= {root[RW-2:0], 1'b0};
        end
        rem_src <= rem_src << 2;
        step <= step + 1'b1;
        if (step == CW'(RootSteps - 1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign mag = root[VW-1:0];
endmodule

// ===== sv/fingertip_force_conditioner.sv =====
// Top level of the fingertip force conditioner: handshake, sequencer, rate filter and tick totals.
`include "fingertip_force_conditioner_defines.svh"
// One sample is taken at a time. The force and displacement norms run side by side in two
// serial norm units: shift-add squaring, then a bit-pair square root. The rate then takes a
// tick-rate product and moving-average products (bit-serial over the 12-bit tick rate and
// the 17-bit weights), then loads the result register and returns to idle to accept the
// next sample. The result sits in an output register; the next sample is accepted while it
// waits, and a finished sample holds in its last state until the output register is free.
module fingertip_force_conditioner import ffc_pkg::*; #(
  parameter int MAX_FINGERS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  ffc_in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output ffc_out_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int VW = ValueWidth;
  localparam int RW = RateWidth;
  localparam int FW = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
  localparam logic signed [RW:0] RateMax = (RW+1)'((64'd1 << (RW - 1)) - 1);
  localparam logic signed [RW:0] RateMin = -RateMax - 1;
  localparam int PW = RW + 18;

  logic [15:0] rate_alpha;
  logic [11:0] ticks_per_second;
  logic [2:0] min_contacts;
  logic [7:0] contact_threshold;

  logic [VW-1:0] prev_magnitude [MAX_FINGERS];
  logic signed [RW-1:0] smoothed_rate [MAX_FINGERS];
  logic rate_started;
  logic [2:0] running_count;
  logic [VW-1:0] running_max;

  ffc_state_t state, state_next;
  ffc_in_t smp;
  ffc_in_t src;
  ffc_unit_ctl_t norm_ctl;
  logic [VW-1:0] fmag, dmag;
  logic fdone, ddone;
  logic [4:0] cnt;
  logic finger_ok;
  logic [FW-1:0] fsel;
  logic signed [VW+1:0] diff;
  logic signed [VW+14:0] raw_acc;
  logic signed [RW-1:0] raw;
  logic signed [PW-1:0] sum;
  logic [16:0] beta;
  logic signed [RW-1:0] old_rate;
  logic signed [PW-1:0] shifted;
  logic signed [RW-1:0] new_rate;
  logic contact;
  logic [2:0] count_next;
  logic [VW-1:0] max_next;
  logic [11:0] tps_eff;
  logic signed [VW-1:0] fx, fy, fz, dx, dy, dz;
  logic norm_done;
  logic out_load;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_alpha <= 16'd6554;
      ticks_per_second <= 12'd500;
      min_contacts <= 3'd2;
      contact_threshold <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegAlpha: rate_alpha <= cfg_data;
        RegTps: ticks_per_second <= cfg_data[11:0];
        RegMinContacts: min_contacts <= cfg_data[2:0];
        RegThreshold: contact_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The norm units load the incoming beat at acceptance and the held sample afterwards.
  assign src = (state == ST_IDLE) ? in_data : smp;

  // Invalid inference forces zero vectors into the norm units.
  assign fx = src.inference_valid ? VW'(src.force_x) : '0;
  assign fy = src.inference_valid ? VW'(src.force_y) : '0;
  assign fz = src.inference_valid ? VW'(src.force_z) : '0;
  assign dx = src.inference_valid ? VW'(src.disp_x) : '0;
  assign dy = src.inference_valid ? VW'(src.disp_y) : '0;
  assign dz = src.inference_valid ? VW'(src.disp_z) : '0;

  assign norm_ctl.start = (state == ST_IDLE) && in_valid;
  assign norm_ctl.busy = (state == ST_SQRT);

  ffc_norm #(.VW(VW)) u_fnorm (
    .clk(clk), .rst(rst), .ctl(norm_ctl),
    .ax(fx), .ay(fy), .az(fz), .mag(fmag), .done(fdone)
  );
  ffc_norm #(.VW(VW)) u_dnorm (
    .clk(clk), .rst(rst), .ctl(norm_ctl),
    .ax(dx), .ay(dy), .az(dz), .mag(dmag), .done(ddone)
  );
  assign norm_done = fdone & ddone;

  assign finger_ok = (32'(smp.finger_index) < 32'(MAX_FINGERS));
  assign fsel = finger_ok ? FW'(smp.finger_index) : '0;
  assign tps_eff = (ticks_per_second == '0) ? DefaultTps : ticks_per_second;
  assign beta = 17'h10000 - 17'(rate_alpha);
  assign old_rate = smoothed_rate[fsel];
  assign contact = smp.inference_valid && (smp.contact_level > contact_threshold);
  assign count_next = (contact && running_count != 3'd7) ? running_count + 3'd1
                                                         : running_count;
  assign max_next = (fmag > running_max) ? fmag : running_max;

  // Round half up, drop 16 fraction bits, then saturate.
  always_comb begin
    shifted = (sum + PW'(32768)) >>> 16;
    if (shifted > PW'(RateMax)) begin
      new_rate = RW'(RateMax);
    end else if (shifted < PW'(RateMin)) begin
      new_rate = RW'(RateMin);
    end else begin
      new_rate = RW'(shifted);
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SQRT;
      ST_SQRT: if (norm_done) state_next = ST_MUL_TPS;
      ST_MUL_TPS: if (cnt == 5'd11) state_next = ST_MUL_EMA;
      ST_MUL_EMA: if (cnt == 5'd16) state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // Datapath: serial tick-rate product, then two serial weight products, then the output load and state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rate_started <= 1'b0;
      running_count <= '0;
      running_max <= '0;
      for (int i = 0; i < MAX_FINGERS; i++) begin
        prev_magnitude[i] <= '0;
        smoothed_rate[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) smp <= in_data;
          cnt <= '0;
        end
        ST_SQRT: begin
          diff <= $signed({2'b00, fmag}) - $signed({2'b00, prev_magnitude[fsel]});
          raw_acc <= '0;
          cnt <= '0;
        end
        ST_MUL_TPS: begin
          if (tps_eff[cnt[3:0]]) begin
            raw_acc <= raw_acc + ((VW+15)'(diff) <<< cnt[3:0]);
          end
          cnt <= (cnt == 5'd11) ? 5'd0 : cnt + 5'd1;
          sum <= '0;
        end
        ST_MUL_EMA: begin
          if (cnt == 5'd16) begin
            if (beta[16]) sum <= sum + (PW'(old_rate) <<< 16);
          end else begin
            if (rate_alpha[cnt[3:0]]) sum <= sum + (PW'(raw) <<< cnt[3:0])
              + (beta[cnt[3:0]] ? (PW'(old_rate) <<< cnt[3:0]) : PW'(0));
            else if (beta[cnt[3:0]]) sum <= sum + (PW'(old_rate) <<< cnt[3:0]);
          end
          cnt <= cnt + 5'd1;
        end
        ST_DONE: begin
          if (out_load) begin
            out_data.finger_out <= smp.finger_index;
            out_data.force_norm <= VW'(fmag);
            out_data.force_slope <= (finger_ok && rate_started) ? new_rate : '0;
            out_data.displacement_magnitude <= VW'(dmag);
            out_data.contact_active <= contact;
            out_data.contact_total <= count_next;
            out_data.peak_force <= VW'(max_next);
            out_data.grasp_found <= smp.last_in_tick && (count_next >= min_contacts);
            out_data.tick_done <= smp.last_in_tick;
            if (finger_ok) begin
              smoothed_rate[fsel] <= rate_started ? new_rate : '0;
              prev_magnitude[fsel] <= fmag;
            end
            if (smp.last_in_tick) begin
              running_count <= '0;
              running_max <= '0;
              rate_started <= 1'b1;
            end else begin
              running_count <= count_next;
              running_max <= max_next;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Saturate the raw rate to the rate width.
  always_comb begin
    if (64'(raw_acc) > 64'(RateMax)) begin
      raw = RW'(RateMax);
    end else if (64'(raw_acc) < 64'(RateMin)) begin
      raw = RW'(RateMin);
    end else begin
      raw = RW'(raw_acc);
    end
  end

  // Checks on the sequencer and tick totals.
  `FFC_ASSERT(a_stall_busy, clk, rst, (state != ST_IDLE) |-> in_stall)
  `FFC_ASSERT(a_done_one, clk, rst, $rose(out_valid) |-> $past(state == ST_DONE))
  `FFC_ASSERT(a_tick_clear, clk, rst,
    (out_valid && out_data.tick_done && $rose(out_valid)) |-> (running_count == '0))
endmodule

// ===== tb/sv/fingertip_force_conditioner_tb.sv =====
// Self-checking testbench of the fingertip force conditioner with a built-in predictor.
module fingertip_force_conditioner_tb import ffc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumFingers = 4;
  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 2000;
  localparam longint RateHi = 64'sd549755813887;
  localparam longint RateLo = -64'sd549755813888;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ffc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ffc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = RegAlpha;
  logic [15:0] cfg_data = '0;

  fingertip_force_conditioner dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor state and register copies.
  logic [15:0] alpha_q;
  logic [11:0] tps_q;
  logic [2:0] min_contacts_q;
  logic [7:0] threshold_q;
  logic [23:0] last_mag [NumFingers];
  longint filt_rate [NumFingers];
  logic rates_live;
  logic [2:0] tick_count;
  logic [23:0] tick_max;

  ffc_in_t sample_queue[$];
  ffc_out_t expected_beats[$];
  int errors = 0;

  // Test bench driven configuration: a request is registered onto the configuration port.
  logic cfg_go = 1'b0;
  logic [1:0] cfg_go_index;
  logic [15:0] cfg_go_data;
  logic hold_req = 1'b0;
  logic [1:0] stall_mode = 2'd0;

  function automatic logic [23:0] norm_of(logic signed [23:0] a, logic signed [23:0] b,
                                         logic signed [23:0] c);
    longint unsigned s, r, bits;
    longint signed va, vb, vc;
    va = a; vb = b; vc = c;
    s = va * va + vb * vb + vc * vc;
    r = 0;
    bits = 64'd1 << 62;
    while (bits > s) bits >>= 2;
    while (bits != 0) begin
      if (s >= r + bits) begin
        s -= r + bits;
        r = (r >> 1) + bits;
      end else begin
        r >>= 1;
      end
      bits >>= 2;
    end
    return r[23:0];
  endfunction

  function automatic longint clamp_rate(longint v);
    if (v > RateHi) return RateHi;
    if (v < RateLo) return RateLo;
    return v;
  endfunction

  // Advance the conditioner model by one sample and return the expected beat.
  function automatic ffc_out_t condition_sample(ffc_in_t s);
    ffc_out_t o;
    logic [23:0] fmag, dmag;
    logic [7:0] level;
    logic touch;
    longint rate, raw, tps, acc;
    int f;
    f = s.finger_index;
    level = s.inference_valid ? s.contact_level : 8'd0;
    fmag = s.inference_valid ? norm_of(s.force_x, s.force_y, s.force_z) : 24'd0;
    dmag = s.inference_valid ? norm_of(s.disp_x, s.disp_y, s.disp_z) : 24'd0;
    touch = level > threshold_q;
    rate = 0;
    if (f < NumFingers) begin
      if (rates_live) begin
        tps = (tps_q == 0) ? 500 : longint'(tps_q);
        raw = clamp_rate((longint'(fmag) - longint'(last_mag[f])) * tps);
        acc = longint'(alpha_q) * raw + (65536 - longint'(alpha_q)) * filt_rate[f] + 32768;
        rate = clamp_rate(acc >>> 16);
      end
      filt_rate[f] = rate;
      last_mag[f] = fmag;
    end
    if (touch && tick_count < 3'd7) tick_count++;
    if (fmag > tick_max) tick_max = fmag;
    o.finger_out = s.finger_index;
    o.force_norm = fmag;
    o.force_slope = rate[39:0];
    o.displacement_magnitude = dmag;
    o.contact_active = touch;
    o.contact_total = tick_count;
    o.peak_force = tick_max;
    o.grasp_found = s.last_in_tick && (tick_count >= min_contacts_q);
    o.tick_done = s.last_in_tick;
    if (s.last_in_tick) begin
      tick_count = '0;
      tick_max = '0;
      rates_live = 1'b1;
    end
    return o;
  endfunction

  // Driver: bursts of beats with random gaps, config writes when requested.
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    cfg_we <= cfg_go;
    cfg_index <= cfg_go_index;
    cfg_data <= cfg_go_data;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_beats.push_back(condition_sample(in_data));
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0 && !cfg_go) begin
          in_data <= sample_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(12);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(150);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off counted here on request.
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    case (stall_mode)
      2'd0: out_stall <= (hold_left > 0);
      2'd1: out_stall <= (hold_left > 0) | ($urandom_range(3) == 0);
      2'd2: out_stall <= (hold_left > 0) | ($urandom_range(1) == 0);
      default: out_stall <= (hold_left > 0) | ($urandom_range(9) < 7);
    endcase
  end

  // Monitor: compare each result beat with the oldest expectation, and fail on a long idle run.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no expectation: %h", out_data);
          errors++;
        end else begin
          ffc_out_t e;
          e = expected_beats.pop_front();
          if (out_data.finger_out !== e.finger_out) begin
            $error("finger_out exp %0d got %0d", e.finger_out, out_data.finger_out); errors++;
          end
          if (out_data.force_norm !== e.force_norm) begin
            $error("force_norm exp %0d got %0d", e.force_norm, out_data.force_norm);
            errors++;
          end
          if (out_data.force_slope !== e.force_slope) begin
            $error("force_slope exp %0d got %0d", e.force_slope, out_data.force_slope);
            errors++;
          end
          if (out_data.displacement_magnitude !== e.displacement_magnitude) begin
            $error("displacement_magnitude exp %0d got %0d", e.displacement_magnitude,
                   out_data.displacement_magnitude); errors++;
          end
          if (out_data.contact_active !== e.contact_active) begin
            $error("contact_active exp %0d got %0d", e.contact_active,
                   out_data.contact_active); errors++;
          end
          if (out_data.contact_total !== e.contact_total) begin
            $error("contact_total exp %0d got %0d", e.contact_total, out_data.contact_total);
            errors++;
          end
          if (out_data.peak_force !== e.peak_force) begin
            $error("peak_force exp %0d got %0d", e.peak_force, out_data.peak_force); errors++;
          end
          if (out_data.grasp_found !== e.grasp_found) begin
            $error("grasp_found exp %0d got %0d", e.grasp_found,
                   out_data.grasp_found); errors++;
          end
          if (out_data.tick_done !== e.tick_done) begin
            $error("tick_done exp %0d got %0d", e.tick_done, out_data.tick_done); errors++;
          end
        end
      end
    end
  end

  function automatic logic signed [23:0] rand_comp(int mode);
    case (mode)
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return $signed(24'($urandom_range(2000)) - 24'd1000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic ffc_in_t rand_sample(logic [1:0] f, logic last);
    ffc_in_t s;
    int m;
    m = $urandom_range(9);
    s.finger_index = f;
    s.inference_valid = ($urandom_range(7) != 0);
    s.contact_level = 8'($urandom);
    s.force_x = rand_comp(m < 2 ? m : $urandom_range(3));
    s.force_y = rand_comp(m < 2 ? m : $urandom_range(3));
    s.force_z = rand_comp(m < 2 ? m : $urandom_range(3));
    s.disp_x = rand_comp($urandom_range(3));
    s.disp_y = rand_comp($urandom_range(3));
    s.disp_z = rand_comp($urandom_range(3));
    s.last_in_tick = last;
    return s;
  endfunction

  task automatic wait_drained();
    while (sample_queue.size() > 0 || in_valid || expected_beats.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_go <= 1'b1;
    cfg_go_index <= idx;
    cfg_go_data <= val;
    @(posedge clk);
    cfg_go <= 1'b0;
    case (idx)
      RegAlpha: alpha_q = val;
      RegTps: tps_q = val[11:0];
      RegMinContacts: min_contacts_q = val[2:0];
      default: threshold_q = val[7:0];
    endcase
    @(posedge clk);
  endtask

  // A tick of samples: fingers mostly in order, last one marked, stray marks at times.
  task automatic push_tick();
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++)
      sample_queue.push_back(rand_sample(2'(($urandom_range(9) == 0) ? $urandom : i),
                                         (i == n - 1) ? 1'b1 : ($urandom_range(19) == 0)));
  endtask

  initial begin
    ffc_in_t s;
    alpha_q = 16'd6554; tps_q = 12'd500; min_contacts_q = 3'd2; threshold_q = 8'd128;
    for (int i = 0; i < NumFingers; i++) begin
      last_mag[i] = '0; filt_rate[i] = 0;
    end
    rates_live = 1'b0; tick_count = '0; tick_max = '0;
    cfg_go_index = RegAlpha; cfg_go_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: first tick with zero rate, extremes, invalid inference, tick ends.
    for (int i = 0; i < 4; i++) begin
      s = rand_sample(2'(i), i == 3);
      s.inference_valid = 1'b1;
      s.contact_level = (i % 2) ? 8'd255 : 8'd128;
      s.force_x = 24'sh7FFFFF; s.force_y = -24'sh800000; s.force_z = 24'sh7FFFFF;
      sample_queue.push_back(s);
    end
    for (int i = 0; i < 8; i++) begin
      s = rand_sample(2'(i), i % 4 == 3);
      s.inference_valid = (i != 2);
      s.force_x = (i < 4) ? 24'sd0 : -24'sh800000;
      s.force_y = (i < 4) ? 24'sd0 : -24'sh800000;
      s.force_z = (i < 4) ? 24'sd0 : -24'sh800000;
      s.contact_level = (i == 5) ? 8'd129 : 8'd0;
      sample_queue.push_back(s);
    end
    // More than seven contacts in one tick.
    for (int i = 0; i < 9; i++) begin
      s = rand_sample(2'(i), i == 8);
      s.inference_valid = 1'b1;
      s.contact_level = 8'd255;
      sample_queue.push_back(s);
    end
    wait_drained();

    // Extreme settings, including zero tick rate and zero contacts needed.
    write_reg(RegAlpha, 16'hFFFF);
    write_reg(RegTps, 16'd4095);
    write_reg(RegMinContacts, 16'd0);
    write_reg(RegThreshold, 16'd0);
    for (int i = 0; i < 8; i++) push_tick();
    wait_drained();
    write_reg(RegAlpha, 16'd0);
    write_reg(RegTps, 16'd0);
    write_reg(RegMinContacts, 16'd4);
    write_reg(RegThreshold, 16'd255);
    for (int i = 0; i < 8; i++) push_tick();
    wait_drained();

    // Pressure: receiver holds off while the sender keeps offering.
    for (int i = 0; i < 4; i++) push_tick();
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    wait_drained();

    // Random phases across settings and stall patterns.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegAlpha, 16'($urandom));
      write_reg(RegTps, 16'($urandom_range(4095)));
      write_reg(RegMinContacts, 16'($urandom_range(4)));
      write_reg(RegThreshold, 16'($urandom_range(255)));
      stall_mode <= 2'(ph);
      for (int i = 0; i < 72; i++) begin
        if ($urandom_range(9) == 0) sample_queue.push_back(rand_sample(2'($urandom),
                                                            1'($urandom)));
        else push_tick();
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/ffc_pkg.sv
sv/ffc_norm.sv
sv/fingertip_force_conditioner.sv
tb/sv/fingertip_force_conditioner_tb.sv
